// File: rtl/core/scp_pkg.sv
// shared constants for the segment closest-point pipeline
package scp_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int PARAM_FRAC_BITS_DEF = 16;
    localparam int NUM_COORDS          = 12;
    localparam int LIMB_W              = 32;

endpackage

// File: rtl/core/scp_mul.sv
// pipelined signed multiplier built from limb-sized partial products
module scp_mul #(
    parameter int AW = 33,
    parameter int BW = 33,
    parameter int SW = 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    vld_in,
    input  logic signed [AW-1:0]    a_in,
    input  logic signed [BW-1:0]    b_in,
    input  logic [SW-1:0]           sb_in,
    output logic                    vld_out,
    output logic signed [AW+BW-1:0] p_out,
    output logic [SW-1:0]           sb_out
);
    import scp_pkg::*;

    localparam int L  = LIMB_W;
    localparam int NA = (AW + L - 1) / L;
    localparam int NB = (BW + L - 1) / L;
    localparam int XA = NA * L;
    localparam int XB = NB * L;
    localparam int PW = AW + BW;
    localparam int RW = XB + L;
    localparam int TW = XA + XB;

    logic [AW-1:0]        a_mag;
    logic [BW-1:0]        b_mag;
    logic [XA-1:0]        ma_reg;
    logic [XB-1:0]        mb_reg;
    logic [2*L-1:0]       pp_reg   [NA][NB];
    logic [2*L-1:0]       pp_next  [NA][NB];
    logic [RW-1:0]        row_reg  [NA];
    logic [RW-1:0]        row_next [NA];
    logic [RW-1:0]        row_acc;
    logic [TW-1:0]        tot;
    logic [PW-1:0]        mag_reg;
    logic [PW-1:0]        mag_next;
    logic signed [PW-1:0] p_reg;
    logic [3:0]           neg_reg;
    logic [4:0]           vld_reg;
    logic [SW-1:0]        sb_reg [5];

    // magnitudes: the most negative value still fits as unsigned
    assign a_mag = a_in[AW-1] ? (~a_in + AW'(1)) : a_in;
    assign b_mag = b_in[BW-1] ? (~b_in + BW'(1)) : b_in;

    always_comb begin
        row_acc = '0;
        tot     = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                pp_next[i][j] = ma_reg[i*L +: L] * mb_reg[j*L +: L];
            end
        end
        for (int i = 0; i < NA; i++) begin
            row_acc = '0;
            for (int j = 0; j < NB; j++) begin
                row_acc = row_acc + (RW'(pp_reg[i][j]) << (L * j));
            end
            row_next[i] = row_acc;
        end
        for (int i = 0; i < NA; i++) begin
            tot = tot + (TW'(row_reg[i]) << (L * i));
        end
        mag_next = tot[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg     <= XA'(a_mag);
            mb_reg     <= XB'(b_mag);
            neg_reg    <= {neg_reg[2:0], a_in[AW-1] ^ b_in[BW-1]};
            pp_reg     <= pp_next;
            row_reg    <= row_next;
            mag_reg    <= mag_next;
            p_reg      <= neg_reg[3] ? (~mag_reg + PW'(1)) : mag_reg;
            sb_reg[0]  <= sb_in;
            for (int k = 1; k < 5; k++) begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], vld_in};
        end
    end

    assign vld_out = vld_reg[4];
    assign p_out   = p_reg;
    assign sb_out  = sb_reg[4];

endmodule

// File: rtl/core/scp_div.sv
// pipelined clamped ratio num/den in [0,1], one quotient bit per stage, rounded
module scp_div #(
    parameter int W  = 64,
    parameter int F  = 16,
    parameter int SW = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                vld_in,
    input  logic signed [W-1:0] num_in,
    input  logic signed [W-1:0] den_in,
    input  logic [SW-1:0]       sb_in,
    output logic                vld_out,
    output logic [F:0]          q_out,
    output logic                clamped_out,
    output logic [SW-1:0]       sb_out
);
    localparam int QW = F + 1;
    localparam logic [QW-1:0] P_ONE = QW'(1) << F;

    logic          neg;
    logic          ge0;
    logic          gt0;
    logic [W-1:0]  rem_reg   [F+1];
    logic [W-1:0]  rem_next  [F+1];
    logic [W-1:0]  den_reg   [F+1];
    logic [F-1:0]  q_reg     [F+1];
    logic [F-1:0]  q_next    [F+1];
    logic          early_reg [F+1];
    logic          one_reg   [F+1];
    logic          clamp_reg [F+1];
    logic [SW-1:0] sb_reg    [F+1];
    logic [W:0]    dbl       [F+1];
    logic          step_ge   [F+1];
    logic [W:0]    dbl_fin;
    logic          up;
    logic [QW-1:0] q_fin;
    logic [QW-1:0] q_out_reg;
    logic          clamp_out_reg;
    logic [SW-1:0] sb_out_reg;
    logic [F+1:0]  vld_reg;

    assign neg = num_in[W-1];
    assign ge0 = num_in >= den_in;
    assign gt0 = num_in > den_in;

    // restoring division: rem stays below den, so the doubled value fits W+1 bits
    always_comb begin
        rem_next[0] = neg || ge0 ? '0 : num_in;
        q_next[0]   = '0;
        dbl[0]      = '0;
        step_ge[0]  = 1'b0;
        for (int k = 1; k <= F; k++) begin
            dbl[k]      = {rem_reg[k-1], 1'b0};
            step_ge[k]  = dbl[k] >= {1'b0, den_reg[k-1]};
            rem_next[k] = step_ge[k] ? W'(dbl[k] - {1'b0, den_reg[k-1]}) : W'(dbl[k]);
            q_next[k]   = {q_reg[k-1][F-2:0], step_ge[k]};
        end
        dbl_fin = {rem_reg[F], 1'b0};
        up      = dbl_fin >= {1'b0, den_reg[F]};
        if (early_reg[F]) begin
            q_fin = one_reg[F] ? P_ONE : '0;
        end else begin
            q_fin = {1'b0, q_reg[F]} + QW'(up);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]   <= rem_next[0];
            q_reg[0]     <= q_next[0];
            den_reg[0]   <= den_in;
            early_reg[0] <= neg || ge0;
            one_reg[0]   <= !neg && ge0;
            clamp_reg[0] <= neg || gt0;
            sb_reg[0]    <= sb_in;
            for (int k = 1; k <= F; k++) begin
                rem_reg[k]   <= rem_next[k];
                q_reg[k]     <= q_next[k];
                den_reg[k]   <= den_reg[k-1];
                early_reg[k] <= early_reg[k-1];
                one_reg[k]   <= one_reg[k-1];
                clamp_reg[k] <= clamp_reg[k-1];
                sb_reg[k]    <= sb_reg[k-1];
            end
            q_out_reg     <= q_fin;
            clamp_out_reg <= clamp_reg[F];
            sb_out_reg    <= sb_reg[F];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[F:0], vld_in};
        end
    end

    assign vld_out     = vld_reg[F+1];
    assign q_out       = q_out_reg;
    assign clamped_out = clamp_out_reg;
    assign sb_out      = sb_out_reg;

endmodule

// File: rtl/core/segment_closest_points_core.sv
// top level: closest-point parameters s and t of two 3d segments
//
// input channel (s_axis_*): one item per segment pair, twelve signed q16.16
// coordinates packed in tdata. result channel (m_axis_*): one item per input,
// param_s and param_t (q1.16, 1 << PARAM_FRAC_BITS means one) in tdata and the
// degenerate flag in tuser; a zero-length segment gives s = t = 0 with the flag.
//
// the datapath is one pipeline: edge differences, dot products, the 2x2
// determinant, then three ratio units (s, t from the quantized s, s again
// from the clamped t), each taking one quotient bit per stage, with a
// limb-split multiplier in front of the second one.
// the pipeline depth is set by the three ratio units and the three 5-stage
// multiplier levels.
// a new item is taken every cycle. the whole pipeline advances together;
// while the output register holds an item the receiver has not taken,
// s_axis_tready is low and every stage holds, so nothing is dropped or
// repeated. reset clears all valid bits; the pipeline needs no warm-up.
module segment_closest_points_core #(
    parameter int COORD_WIDTH     = scp_pkg::COORD_WIDTH_DEF,
    parameter int PARAM_FRAC_BITS = scp_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
    // b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z, zero fill
    input  logic [((scp_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // param_s, param_t, zero fill
    output logic [((2*(PARAM_FRAC_BITS+1)+7)/8)*8-1:0]           m_axis_tdata,
    // degenerate
    output logic [0:0]                                           m_axis_tuser
);
    import scp_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int F      = PARAM_FRAC_BITS;
    localparam int QW     = F + 1;
    localparam int EW     = CW + 1;
    localparam int DW     = 2 * EW + 2;
    localparam int NW     = 2 * DW + 1;
    localparam int TW     = DW + F + 3;
    localparam int SNW    = DW + 1;
    localparam int OUT_W  = 2 * QW;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int NDOT   = 15;
    localparam logic [QW-1:0] P_ONE = QW'(1) << F;

    typedef struct packed {
        logic                 deg;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
        logic signed [DW-1:0] s1;
        logic signed [DW-1:0] s2;
        logic signed [DW-1:0] r;
    } dots_t;

    typedef struct packed {
        dots_t dots;
        logic  dz;
    } sol_t;

    typedef struct packed {
        sol_t          sol;
        logic [QW-1:0] s;
    } tstage_t;

    typedef struct packed {
        logic          deg;
        logic [QW-1:0] s;
        logic [QW-1:0] t;
        logic          tcl;
    } fin_t;

    logic en;

    // edge differences
    logic signed [EW-1:0] crd [NUM_COORDS];
    logic signed [EW-1:0] e1_reg  [3];
    logic signed [EW-1:0] e2_reg  [3];
    logic signed [EW-1:0] e12_reg [3];
    logic                 a_vld_reg;

    // dot products
    logic signed [EW-1:0]   dot_a [NDOT];
    logic signed [EW-1:0]   dot_b [NDOT];
    logic signed [2*EW-1:0] dot_p [NDOT];
    logic [NDOT-1:0]        dot_vld;
    dots_t                  dots_next;
    dots_t                  dots_reg;
    logic                   b_vld_reg;

    // determinant and s numerator
    logic signed [DW-1:0]   l2_a [4];
    logic signed [DW-1:0]   l2_b [4];
    logic signed [2*DW-1:0] l2_p [4];
    logic [3:0]             l2_vld;
    dots_t                  l2_sb [4];
    logic signed [NW-1:0]   den_reg;
    logic signed [NW-1:0]   snum_reg;
    dots_t                  c_dots_reg;
    logic                   c_vld_reg;
    sol_t                   c_sol;

    // first ratio: s
    logic          div1_vld;
    logic [QW-1:0] div1_q;
    sol_t          div1_sb;
    logic [QW-1:0] s_val;
    tstage_t       m3_sb_in;

    // t numerator
    logic signed [QW:0]      m3_a;
    logic signed [DW+QW:0]   m3_p;
    logic                    m3_vld;
    tstage_t                 m3_sb;
    logic signed [TW-1:0]    tnum_next;
    logic signed [TW-1:0]    tden_next;
    logic signed [TW-1:0]    tnum_reg;
    logic signed [TW-1:0]    tden_reg;
    tstage_t                 d_reg;
    logic                    d_vld_reg;

    // second ratio: t
    logic          div2_vld;
    logic [QW-1:0] div2_q;
    logic          div2_cl;
    tstage_t       div2_sb;
    logic signed [SNW-1:0] snum2_reg;
    logic signed [SNW-1:0] den3_reg;
    fin_t                  e_reg;
    logic                  e_vld_reg;

    // third ratio: s from the clamped t
    logic          div3_vld;
    logic [QW-1:0] div3_q;
    fin_t          div3_sb;

    logic [QW-1:0] s_fin;
    logic [QW-1:0] t_fin;
    logic              m_vld_reg;
    logic [OUT_TW-1:0] m_data_reg;
    logic              m_deg_reg;

    assign en            = !m_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage a: sign-extended differences ----
    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            crd[k] = EW'($signed(s_axis_tdata[k*CW +: CW]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                e1_reg[c]  <= crd[3+c] - crd[c];
                e2_reg[c]  <= crd[9+c] - crd[6+c];
                e12_reg[c] <= crd[6+c] - crd[c];
            end
        end
    end

    // ---- dot product multipliers: d1, d2, s1, s2, r ----
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dot_a[c]      = e1_reg[c];  dot_b[c]      = e1_reg[c];
            dot_a[3+c]    = e2_reg[c];  dot_b[3+c]    = e2_reg[c];
            dot_a[6+c]    = e1_reg[c];  dot_b[6+c]    = e12_reg[c];
            dot_a[9+c]    = e2_reg[c];  dot_b[9+c]    = e12_reg[c];
            dot_a[12+c]   = e1_reg[c];  dot_b[12+c]   = e2_reg[c];
        end
    end

    for (genvar gi = 0; gi < NDOT; gi++) begin : g_dot
        scp_mul #(.AW(EW), .BW(EW), .SW(1)) u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (a_vld_reg),
            .a_in    (dot_a[gi]),
            .b_in    (dot_b[gi]),
            .sb_in   (1'b0),
            .vld_out (dot_vld[gi]),
            .p_out   (dot_p[gi]),
            .sb_out  ()
        );
    end

    always_comb begin
        dots_next.d1  = DW'(dot_p[0])  + DW'(dot_p[1])  + DW'(dot_p[2]);
        dots_next.d2  = DW'(dot_p[3])  + DW'(dot_p[4])  + DW'(dot_p[5]);
        dots_next.s1  = DW'(dot_p[6])  + DW'(dot_p[7])  + DW'(dot_p[8]);
        dots_next.s2  = DW'(dot_p[9])  + DW'(dot_p[10]) + DW'(dot_p[11]);
        dots_next.r   = DW'(dot_p[12]) + DW'(dot_p[13]) + DW'(dot_p[14]);
        dots_next.deg = (dots_next.d1 == '0) || (dots_next.d2 == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dots_reg <= dots_next;
        end
    end

    // ---- d1*d2, r*r, s1*d2, s2*r ----
    always_comb begin
        l2_a[0] = dots_reg.d1; l2_b[0] = dots_reg.d2;
        l2_a[1] = dots_reg.r;  l2_b[1] = dots_reg.r;
        l2_a[2] = dots_reg.s1; l2_b[2] = dots_reg.d2;
        l2_a[3] = dots_reg.s2; l2_b[3] = dots_reg.r;
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_l2
        scp_mul #(.AW(DW), .BW(DW), .SW($bits(dots_t))) u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (b_vld_reg),
            .a_in    (l2_a[gi]),
            .b_in    (l2_b[gi]),
            .sb_in   (dots_reg),
            .vld_out (l2_vld[gi]),
            .p_out   (l2_p[gi]),
            .sb_out  (l2_sb[gi])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg    <= NW'(l2_p[0]) - NW'(l2_p[1]);
            snum_reg   <= NW'(l2_p[2]) - NW'(l2_p[3]);
            c_dots_reg <= l2_sb[0];
        end
    end

    assign c_sol.dots = c_dots_reg;
    assign c_sol.dz   = (den_reg == '0);

    scp_div #(.W(NW), .F(F), .SW($bits(sol_t))) u_div_s (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .vld_in      (c_vld_reg),
        .num_in      (snum_reg),
        .den_in      (den_reg),
        .sb_in       (c_sol),
        .vld_out     (div1_vld),
        .q_out       (div1_q),
        .clamped_out (),
        .sb_out      (div1_sb)
    );

    // parallel segments start from s = 0
    assign s_val        = div1_sb.dz ? '0 : div1_q;
    assign m3_a         = {1'b0, s_val};
    assign m3_sb_in.sol = div1_sb;
    assign m3_sb_in.s   = s_val;

    scp_mul #(.AW(QW+1), .BW(DW), .SW($bits(tstage_t))) u_mul_t (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (div1_vld),
        .a_in    (m3_a),
        .b_in    (div1_sb.dots.r),
        .sb_in   (m3_sb_in),
        .vld_out (m3_vld),
        .p_out   (m3_p),
        .sb_out  (m3_sb)
    );

    always_comb begin
        if (m3_sb.sol.dz) begin
            tnum_next = -TW'(m3_sb.sol.dots.s2);
            tden_next = TW'(m3_sb.sol.dots.d2);
        end else begin
            tnum_next = TW'(m3_p) - (TW'(m3_sb.sol.dots.s2) <<< F);
            tden_next = TW'(m3_sb.sol.dots.d2) <<< F;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tnum_reg <= tnum_next;
            tden_reg <= tden_next;
            d_reg    <= m3_sb;
        end
    end

    scp_div #(.W(TW), .F(F), .SW($bits(tstage_t))) u_div_t (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .vld_in      (d_vld_reg),
        .num_in      (tnum_reg),
        .den_in      (tden_reg),
        .sb_in       (d_reg),
        .vld_out     (div2_vld),
        .q_out       (div2_q),
        .clamped_out (div2_cl),
        .sb_out      (div2_sb)
    );

    // s numerator for the clamped t: s1 at t = 0, r + s1 at t = 1
    always_ff @(posedge aclk) begin
        if (en) begin
            snum2_reg <= (div2_q == P_ONE) ?
                         SNW'(div2_sb.sol.dots.r) + SNW'(div2_sb.sol.dots.s1) :
                         SNW'(div2_sb.sol.dots.s1);
            den3_reg  <= SNW'(div2_sb.sol.dots.d1);
            e_reg.deg <= div2_sb.sol.dots.deg;
            e_reg.s   <= div2_sb.s;
            e_reg.t   <= div2_q;
            e_reg.tcl <= div2_cl;
        end
    end

    scp_div #(.W(SNW), .F(F), .SW($bits(fin_t))) u_div_s2 (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .vld_in      (e_vld_reg),
        .num_in      (snum2_reg),
        .den_in      (den3_reg),
        .sb_in       (e_reg),
        .vld_out     (div3_vld),
        .q_out       (div3_q),
        .clamped_out (),
        .sb_out      (div3_sb)
    );

    always_comb begin
        s_fin = div3_sb.tcl ? div3_q : div3_sb.s;
        t_fin = div3_sb.t;
        if (div3_sb.deg) begin
            s_fin = '0;
            t_fin = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= OUT_TW'({t_fin, s_fin});
            m_deg_reg  <= div3_sb.deg;
        end
    end

    // valid bits of the stages owned here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_axis_tvalid;
            b_vld_reg <= dot_vld[0];
            c_vld_reg <= l2_vld[0];
            d_vld_reg <= m3_vld;
            e_vld_reg <= div2_vld;
            m_vld_reg <= div3_vld;
        end
    end

    assign m_axis_tvalid   = m_vld_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_deg_reg;

    // parallel multipliers must stay in lockstep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dot_vld == '0) || (dot_vld == '1))
        else $error("dot product multipliers out of step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (l2_vld == '0) || (l2_vld == '1))
        else $error("determinant multipliers out of step");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[QW-1:0] <= P_ONE) &&
                          (m_axis_tdata[2*QW-1:QW] <= P_ONE))
        else $error("parameter above one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("degenerate item with nonzero parameters");

endmodule

// File: dv/segment_closest_points_core_test.sv
// testbench for the segment closest-point core: stream stimulus, exact predictor, scoreboard
`timescale 1ns / 100ps

typedef logic signed [255:0] wide_t;

typedef struct {
    logic [16:0] param_s;
    logic [16:0] param_t;
    logic        degenerate;
} contact_t;

class ClosestPointBoard;
    contact_t pending[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    // num/den clamped to [0,1] and rounded to 2^-16, halves up
    function automatic logic [16:0] quantize(wide_t num, wide_t den, output bit clamped);
        wide_t one, q, rem;
        one = wide_t'(65536);
        clamped = 0;
        if (num < 0) begin
            clamped = 1;
            return 17'd0;
        end
        if (num >= den) begin
            if (num > den) clamped = 1;
            return one[16:0];
        end
        if (num == 0) return 17'd0;
        q   = (num * one) / den;
        rem = (num * one) - q * den;
        if (2 * rem >= den) q = q + 1;
        return q[16:0];
    endfunction

    function automatic wide_t dot(wide_t p[3], wide_t q[3]);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function void note(logic [383:0] d);
        wide_t e1[3], e2[3], e12[3];
        wide_t d1, d2, s1, s2, r, den, tnum, tden, snum, one;
        logic signed [31:0] as, ae, bs, be;
        logic [16:0] s, t;
        contact_t c;
        bit clamped;
        one = wide_t'(65536);
        for (int i = 0; i < 3; i++) begin
            as = d[32*i +: 32];
            ae = d[32*(3+i) +: 32];
            bs = d[32*(6+i) +: 32];
            be = d[32*(9+i) +: 32];
            e1[i]  = wide_t'(ae) - wide_t'(as);
            e2[i]  = wide_t'(be) - wide_t'(bs);
            e12[i] = wide_t'(bs) - wide_t'(as);
        end
        d1 = dot(e1, e1);
        d2 = dot(e2, e2);
        s1 = dot(e1, e12);
        s2 = dot(e2, e12);
        r  = dot(e1, e2);
        if (d1 == 0 || d2 == 0) begin
            c.param_s = 0;
            c.param_t = 0;
            c.degenerate = 1;
        end else begin
            den = d1 * d2 - r * r;
            if (den == 0) begin
                s    = 0;
                tnum = -s2;
                tden = d2;
            end else begin
                s    = quantize(s1 * d2 - s2 * r, den, clamped);
                tnum = wide_t'(s) * r - s2 * one;
                tden = d2 * one;
            end
            t = quantize(tnum, tden, clamped);
            if (clamped) begin
                snum = (t == one[16:0]) ? r + s1 : s1;
                s = quantize(snum, d1, clamped);
            end
            c.param_s = s;
            c.param_t = t;
            c.degenerate = 0;
        end
        pending = {pending, c};
    endfunction

    function void check(logic [39:0] d, logic u);
        contact_t c;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result s=%h t=%h deg=%b", $time, d[16:0], d[33:17], u);
            errors++;
            return;
        end
        c = pending.pop_front();
        if (d[16:0] !== c.param_s) begin
            $display("%0t: param_s expected %h actual %h", $time, c.param_s, d[16:0]);
            errors++;
        end
        if (d[33:17] !== c.param_t) begin
            $display("%0t: param_t expected %h actual %h", $time, c.param_t, d[33:17]);
            errors++;
        end
        if (u !== c.degenerate) begin
            $display("%0t: degenerate expected %b actual %b", $time, c.degenerate, u);
            errors++;
        end
    endfunction
endclass

module segment_closest_points_core_test;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [39:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    ClosestPointBoard board = new();
    int idle_cycles = 0;
    bit calm = 0;

    always #10 aclk = ~aclk;

    segment_closest_points_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) board.note(s_axis_tdata);
        if (aresetn && m_axis_tvalid && m_axis_tready) board.check(m_axis_tdata, m_axis_tuser[0]);
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [383:0] pack(int c[12]);
        logic [383:0] d;
        for (int i = 0; i < 12; i++) d[32*i +: 32] = c[i];
        return d;
    endfunction

    task automatic send(logic [383:0] d);
        int g;
        bit ok;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= d;
        do begin
            @(negedge aclk);
            ok = s_axis_tready;
            @(posedge aclk);
        end while (!ok);
    endtask

    function automatic int small_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [383:0] random_pair();
        int c[12];
        int k, m, sp;
        k = $urandom_range(0, 99);
        sp = ($urandom_range(0, 3) == 0) ? 32'h7fffffff : (1 << $urandom_range(4, 24));
        if (k < 15) begin
            for (int i = 0; i < 12; i++) c[i] = $urandom;
        end else begin
            for (int i = 0; i < 12; i++) c[i] = small_coord(sp > 32'h40000000 ? 32'h3fffffff : sp);
            if (k < 30) begin
                // parallel: second segment is a scaled copy of the first direction
                m = $urandom_range(0, 4) - 2;
                if (m == 0) m = 3;
                for (int i = 0; i < 3; i++) c[9+i] = c[6+i] + m * (c[3+i] - c[i]) / 2;
            end else if (k < 36) begin
                for (int i = 0; i < 3; i++) c[3+i] = c[i];
            end else if (k < 42) begin
                for (int i = 0; i < 3; i++) c[9+i] = c[6+i];
            end
        end
        return pack(c);
    endfunction

    task automatic directed();
        int c[12];
        int base[12];
        base = '{0, 0, 0, 65536, 0, 0, 32768, -65536, 0, 32768, 65536, 0};
        send(pack(base));                                   // crossing at the middle
        c = base; c[6] = 200000; c[9] = 200000;
        send(pack(c));                                      // s clamped high
        c = base; c[6] = -100000; c[9] = -100000;
        send(pack(c));                                      // s clamped low
        c = base; c[7] = 100000; c[10] = 300000;
        send(pack(c));                                      // t clamped low
        c = base; c[7] = -300000; c[10] = -100000;
        send(pack(c));                                      // t clamped high
        c = base; c[3] = 0;
        send(pack(c));                                      // zero-length first segment
        c = base; c[9] = c[6]; c[10] = c[7];
        send(pack(c));                                      // zero-length second segment
        for (int i = 0; i < 12; i++) c[i] = 0;
        send(pack(c));                                      // both points
        c = '{0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 65536, 0};
        send(pack(c));                                      // parallel, overlapping
        c = '{0, 0, 0, 65536, 0, 0, 200000, 65536, 0, 300000, 65536, 0};
        send(pack(c));                                      // parallel, beyond the end
        c = '{0, 0, 0, 65536, 0, 0, -65536, 5, 0, -300000, 5, 0};
        send(pack(c));                                      // parallel, before the start
        for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 32'h7fffffff : 32'h80000000;
        send(pack(c));
        for (int i = 0; i < 12; i++) c[i] = (i < 3 || (i >= 6 && i < 9)) ? 32'h80000000 : 32'h7fffffff;
        send(pack(c));                                      // full-range, parallel
        for (int i = 0; i < 12; i++) c[i] = (i / 3 == 1 || i / 3 == 2) ? 32'h7fffffff : 32'h80000000;
        send(pack(c));
        for (int i = 0; i < 12; i++) c[i] = (i < 6) ? 32'h80000000 : 32'h7fffffff;
        send(pack(c));
        c = '{0, 0, 0, 1, 0, 0, 0, 0, 1, 1, 1, 1};
        send(pack(c));                                      // one-lsb segments
        c = '{0, 0, 0, 65536, 65536, 0, 0, 65536, 0, 65536, 0, 0};
        send(pack(c));                                      // crossing diagonals, exact half on both
    endtask

    // receiver: stall bursts mostly short, some long, with calm stretches
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            m_axis_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            g = gap_len();
            if (g > 0) begin
                m_axis_tready <= 0;
                repeat (g) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        directed();
        for (int n = 0; n < 450; n++) begin
            if (n % 100 == 50) calm = 1;
            if (n % 100 == 80) calm = 0;
            send(random_pair());
        end
        s_axis_tvalid <= 0;
        do @(posedge aclk); while (board.pending.size() != 0);
        repeat (100) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/scp_pkg.sv
rtl/core/scp_mul.sv
rtl/core/scp_div.sv
rtl/core/segment_closest_points_core.sv
dv/segment_closest_points_core_test.sv
